// ----- sv/heap_sort_engine_core_macros.svh -----
// Assertion macros shared by the heap sort engine RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef HEAP_SORT_ENGINE_CORE_MACROS_SVH
`define HEAP_SORT_ENGINE_CORE_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define HSE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold on every rising edge outside reset.
`define HSE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

`endif

// ----- sv/hse_pkg.sv -----
// Package for the heap sort engine: fixed port widths and compare result type.
// No dependencies.
package hse_pkg;

    localparam int unsigned IN_W   = 32;  // key_value port width
    localparam int unsigned OUT_W  = 32;  // sorted_value port width
    localparam int unsigned WIDE_W = 64;  // widest supported key

    // Result of one compare step of the sift-down
    typedef struct packed {
        logic take_right;  // right child chosen
        logic swap;        // parent strictly smaller than chosen child
    } t_cmp_res;

endpackage

// ----- sv/hse_mem.sv -----
// Key store: one write port, two registered read ports.
// No dependencies.
module hse_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ----- sv/hse_cmp.sv -----
// Shared compare unit of the sift-down: child choice and swap decision.
// Depends on hse_pkg.
module hse_cmp
    import hse_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  logic [WIDTH-1:0] i_node_val,
    input  logic [WIDTH-1:0] i_left_val,
    input  logic [WIDTH-1:0] i_right_val,
    input  logic             i_right_ok,
    output t_cmp_res         o_res,
    output logic [WIDTH-1:0] o_pick_val
);

    // ties go to the right child
    always_comb begin
        o_res.take_right = i_right_ok && (i_left_val <= i_right_val);
        o_pick_val       = o_res.take_right ? i_right_val : i_left_val;
        o_res.swap       = i_node_val < o_pick_val;
    end

endmodule

// ----- sv/heap_sort_engine_core.sv -----
// Heap sort engine top level: load sequencer, heap build/extract and emit.
// Depends on hse_pkg, hse_mem, hse_cmp and heap_sort_engine_core_macros.svh.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------
//  request   | start / busy (accept when | i_key_value, i_is_last
//            | start high and busy low)  |
//  result    | o_result_valid, 1 cycle   | o_sorted_value, o_last_out, o_overflow
//
// A key request without is_last is taken at once; busy stays low.
// The is_last request starts the sort of N stored keys: a heap build and extraction
// paced by the single compare unit and the two read ports of the key store,
// then the N results, one key per cycle, each strobed in the cycle after its read.
// busy rises the cycle after the is_last request and falls as the final result shows.
// Results cannot be stalled; synchronous active-low reset clears control state only.
`include "heap_sort_engine_core_macros.svh"

module heap_sort_engine_core
    import hse_pkg::*;
#(
    parameter int unsigned STORE_DEPTH = 64,
    parameter int unsigned KEY_WIDTH   = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [IN_W-1:0]  i_key_value,
    input  logic             i_is_last,
    output logic             o_result_valid,
    output logic [OUT_W-1:0] o_sorted_value,
    output logic             o_last_out,
    output logic             o_overflow
);

    localparam int unsigned AW = $clog2(STORE_DEPTH);      // store index
    localparam int unsigned CW = $clog2(STORE_DEPTH + 1);  // key count

    typedef enum logic [3:0] {
        ST_IDLE,     // loading keys
        ST_SORT,     // set up heap build
        ST_TOP,      // read the sift root
        ST_NODE,     // capture the sift root value
        ST_CHILD,    // read both children
        ST_CMP,      // compare, move chosen child up
        ST_PUT,      // drop the held value into the hole
        ST_SWAP_RD,  // read root and heap end
        ST_SWAP_WR,  // root to heap end, end value held for sift
        ST_EMIT      // stream the sorted keys
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;     // keys stored in this set
    logic              r_dropped;   // a key of this set was lost
    logic              r_extract;   // 0: heap build, 1: extraction
    logic [AW-1:0]     r_top;       // build: current sift root
    logic [AW-1:0]     r_node;      // sift: current hole
    logic [AW-1:0]     r_hend;      // sift: last index in the heap
    logic [AW-1:0]     r_idx;       // extract: heap end being filled
    logic [AW-1:0]     r_k;         // emit index
    logic [KEY_WIDTH-1:0] r_node_val;  // value travelling down the heap
    logic              r_valid;
    logic              r_last;
    logic              r_ovf;

    // memory port
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [KEY_WIDTH-1:0] w_wdata;
    logic [AW-1:0]        w_raddr_a;
    logic [AW-1:0]        w_raddr_b;
    logic [KEY_WIDTH-1:0] w_rd_a;
    logic [KEY_WIDTH-1:0] w_rd_b;

    // compare unit
    t_cmp_res             w_cmp;
    logic [KEY_WIDTH-1:0] w_pick_val;

    logic                 w_accept;
    logic [CW-1:0]        w_cnt_m1;
    logic [CW-1:0]        w_half_m1;
    logic [AW+1:0]        w_left;
    logic [AW+1:0]        w_right;
    logic [AW+1:0]        w_hend_x;
    logic                 w_right_ok;
    logic [WIDE_W-1:0]    w_key_wide;
    logic [WIDE_W-1:0]    w_out_wide;

    assign w_accept   = start && !busy;
    assign w_cnt_m1   = r_count - CW'(1);
    assign w_half_m1  = (r_count >> 1) - CW'(1);
    assign w_left     = {1'b0, r_node, 1'b1};
    assign w_right    = w_left + (AW+2)'(1);
    assign w_hend_x   = {2'b00, r_hend};
    assign w_right_ok = w_right <= w_hend_x;
    assign w_key_wide = WIDE_W'(i_key_value);
    assign w_out_wide = WIDE_W'(w_rd_a);

    hse_mem #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (KEY_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    hse_cmp #(
        .WIDTH (KEY_WIDTH)
    ) u_cmp (
        .i_node_val  (r_node_val),
        .i_left_val  (w_rd_a),
        .i_right_val (w_rd_b),
        .i_right_ok  (w_right_ok),
        .o_res       (w_cmp),
        .o_pick_val  (w_pick_val)
    );

    // store port steering
    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_node;
        w_wdata   = r_node_val;
        w_raddr_a = r_node;
        w_raddr_b = r_node;
        unique case (r_state)
            ST_IDLE: begin
                w_we    = w_accept && (r_count < CW'(STORE_DEPTH));
                w_waddr = r_count[AW-1:0];
                w_wdata = w_key_wide[KEY_WIDTH-1:0];
            end
            ST_CHILD: begin
                w_raddr_a = w_left[AW-1:0];
                w_raddr_b = w_right[AW-1:0];
            end
            ST_CMP: begin
                // chosen child moves up into the hole
                w_we    = w_cmp.swap;
                w_wdata = w_pick_val;
            end
            ST_PUT: begin
                w_we = 1'b1;
            end
            ST_SWAP_RD: begin
                w_raddr_a = '0;
                w_raddr_b = r_idx;
            end
            ST_SWAP_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = w_rd_a;
            end
            ST_EMIT: begin
                w_raddr_a = r_k;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_extract <= 1'b0;
            r_valid   <= 1'b0;
            r_last    <= 1'b0;
            r_ovf     <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (r_count < CW'(STORE_DEPTH)) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                        if (i_is_last) begin
                            r_state <= ST_SORT;
                        end
                    end
                end
                ST_SORT: begin
                    r_k <= '0;
                    if (r_count < CW'(2)) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_top     <= w_half_m1[AW-1:0];
                        r_node    <= w_half_m1[AW-1:0];
                        r_hend    <= w_cnt_m1[AW-1:0];
                        r_idx     <= w_cnt_m1[AW-1:0];
                        r_extract <= 1'b0;
                        r_state   <= ST_TOP;
                    end
                end
                ST_TOP: begin
                    r_state <= ST_NODE;
                end
                ST_NODE: begin
                    r_node_val <= w_rd_a;
                    r_state    <= ST_CHILD;
                end
                ST_CHILD: begin
                    if (w_left > w_hend_x) begin
                        r_state <= ST_PUT;
                    end else begin
                        r_state <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    if (w_cmp.swap) begin
                        r_node  <= w_cmp.take_right ? w_right[AW-1:0] : w_left[AW-1:0];
                        r_state <= ST_CHILD;
                    end else begin
                        r_state <= ST_PUT;
                    end
                end
                ST_PUT: begin
                    if (!r_extract) begin
                        if (r_top == '0) begin
                            r_extract <= 1'b1;
                            r_state   <= ST_SWAP_RD;
                        end else begin
                            r_top   <= r_top - AW'(1);
                            r_node  <= r_top - AW'(1);
                            r_state <= ST_TOP;
                        end
                    end else if (r_idx == AW'(1)) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_idx   <= r_idx - AW'(1);
                        r_state <= ST_SWAP_RD;
                    end
                end
                ST_SWAP_RD: begin
                    r_state <= ST_SWAP_WR;
                end
                ST_SWAP_WR: begin
                    // old root parked at the heap end, end value sifts from the root
                    r_node_val <= w_rd_b;
                    r_node     <= '0;
                    r_hend     <= r_idx - AW'(1);
                    r_state    <= ST_CHILD;
                end
                ST_EMIT: begin
                    // read data lands with the strobe in the following cycle
                    r_valid <= 1'b1;
                    r_last  <= (r_k == w_cnt_m1[AW-1:0]);
                    r_ovf   <= r_dropped;
                    if (r_k == w_cnt_m1[AW-1:0]) begin
                        r_count   <= '0;
                        r_dropped <= 1'b0;
                        r_state   <= ST_IDLE;
                    end else begin
                        r_k <= r_k + AW'(1);
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_valid;
    assign o_sorted_value = w_out_wide[OUT_W-1:0];
    assign o_last_out     = r_last;
    assign o_overflow     = r_ovf;

    `HSE_ASSERT_IMP(a_strobe_after_emit, i_clk, i_rst_n, r_valid,
                    $past(r_state == ST_EMIT), "result strobe without emit cycle")
    `HSE_ASSERT_IMP(a_last_clears_set, i_clk, i_rst_n, r_valid && r_last,
                    (r_state == ST_IDLE) && (r_count == '0) && !r_dropped,
                    "set state not cleared after final result")
    `HSE_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(STORE_DEPTH),
                       "key count beyond store depth")
    `HSE_ASSERT_IMP(a_cmp_in_heap, i_clk, i_rst_n, r_state == ST_CMP,
                    w_left <= w_hend_x, "compare on a child outside the heap")

endmodule
